>>> hdl/serial_mouse_packet_encoder_top_macros.svh
// Assertion macros shared by the serial mouse packet encoder checker.
`ifndef SERIAL_MOUSE_PACKET_ENCODER_TOP_MACROS_SVH
`define SERIAL_MOUSE_PACKET_ENCODER_TOP_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define SMPE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define SMPE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/smpe_pkg.sv
// Package with the types, constants and helper functions of the serial mouse packet encoder.
package smpe_pkg;

    localparam int RING_DEPTH_DEF = 256;

    localparam logic KIND_SCAN    = 1'b0;
    localparam logic KIND_CONTROL = 1'b1;

    localparam logic PROTO_THREE = 1'b0;
    localparam logic PROTO_FIVE  = 1'b1;
    localparam logic PROTO_RESET = PROTO_FIVE;

    localparam logic [7:0] ID_BYTE_M = 8'h4D;
    localparam logic [7:0] ID_BYTE_3 = 8'h33;

    localparam logic [2:0] BYTE_HEAD = 3'd0;
    localparam logic [2:0] BYTE_X    = 3'd1;
    localparam logic [2:0] BYTE_Y    = 3'd2;
    localparam logic [2:0] BYTE_MID  = 3'd3;
    localparam logic [2:0] BYTE_PAD1 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ID_M,
        ST_ID_3,
        ST_ENCODE,
        ST_READ,
        ST_SEND
    } state_t;

    function automatic logic [7:0] clamp_chunk(input logic signed [12:0] v);
        if (v < -13'sd128) begin
            return 8'h80;
        end else if (v > 13'sd127) begin
            return 8'h7F;
        end else begin
            return v[7:0];
        end
    endfunction

endpackage

>>> hdl/serial_mouse_packet_encoder_top.sv
// Top level of the serial mouse packet encoder.
//
// The s_ channel takes one item per transfer: s_tuser selects a scan tick or a
// control-line update, and s_tdata carries the position counters, buttons and
// line levels. The m_ channel returns at most one serial byte per scan tick.
// The cfg channel writes the protocol bit and is always ready; the user must write
// it only while the block is idle, which the block itself does not enforce.
// A control update that requests identification queues the two identification
// bytes through the ST_ID_M and ST_ID_3 states. A scan tick with bytes already
// queued reads one byte in ST_READ and registers it onto m_tdata in ST_SEND. A scan
// tick with new motion into an empty queue first writes its packets into the byte
// ring, one byte per cycle through the single write port, then reads and sends.
// The block takes no new item until the current one is finished.
// When the receiver stalls, the output register holds its byte and the block may
// take one more item; a second byte waits in the sequencer until m_tready frees
// the register.
// Reset empties the ring, clears the saved positions and disables scanning; the
// protocol bit returns to the five-byte format.
module serial_mouse_packet_encoder_top import smpe_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // x_count[11:0], y_count[23:12], buttons[26:24], dtr[27], rts[28]
    input  logic        s_tuser,  // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // rx_byte[7:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    state_t state_reg, state_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [11:0] last_x_reg, last_x_next;
    logic [11:0] last_y_reg, last_y_next;
    logic [2:0] last_btn_reg, last_btn_next;
    logic scan_en_reg, scan_en_next;
    logic prev_dtr_reg, prev_dtr_next;
    logic prev_rts_reg, prev_rts_next;
    logic protocol_reg, protocol_next;
    logic [2:0] byte_cnt_reg, byte_cnt_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic signed [12:0] dx_reg, dx_next;
    logic signed [12:0] dy_reg, dy_next;
    logic [2:0] nb_reg, nb_next;
    logic mid_chg_reg, mid_chg_next;

    logic [11:0] in_x;
    logic [11:0] in_y;
    logic [2:0] in_btn;
    logic in_dtr;
    logic in_rts;
    logic accept;
    logic ring_empty;
    logic ctl_change;
    logic [11:0] d_x;
    logic [11:0] d_y;
    logic [2:0] btn_chg;
    logic new_motion;
    logic [7:0] cx;
    logic [7:0] cy;
    logic signed [12:0] rem_x;
    logic signed [12:0] rem_y;
    logic last_byte;
    logic chunk_done;
    logic [7:0] enc_byte;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic send_free;
    logic id_request;

    logic ram_we;
    logic [7:0] ram_wdata;
    logic ram_re;
    logic [7:0] ram_rdata;

    assign in_x   = s_tdata[11:0];
    assign in_y   = s_tdata[23:12];
    assign in_btn = s_tdata[26:24];
    assign in_dtr = s_tdata[27];
    assign in_rts = s_tdata[28];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign accept     = s_tvalid && s_tready;
    assign ring_empty = (wp_reg == rp_reg);
    assign ctl_change = (in_dtr != prev_dtr_reg) || (in_rts != prev_rts_reg);
    assign id_request = ctl_change && in_dtr && in_rts && !prev_rts_reg
                        && (protocol_reg == PROTO_THREE);
    assign d_x        = in_x - last_x_reg;
    assign d_y        = in_y - last_y_reg;
    assign btn_chg    = in_btn ^ last_btn_reg;
    assign new_motion = (d_x != 12'd0) || (d_y != 12'd0) || (btn_chg != 3'd0);

    assign cx    = clamp_chunk(dx_reg);
    assign cy    = clamp_chunk(dy_reg);
    assign rem_x = dx_reg - $signed({{5{cx[7]}}, cx});
    assign rem_y = dy_reg - $signed({{5{cy[7]}}, cy});

    assign last_byte = (protocol_reg == PROTO_THREE)
                       ? (byte_cnt_reg == (mid_chg_reg ? BYTE_MID : BYTE_Y))
                       : (byte_cnt_reg == BYTE_PAD1);
    assign chunk_done = last_byte && (rem_x == 13'sd0) && (rem_y == 13'sd0);

    assign wp_inc    = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign send_free = !m_tvalid_reg || m_tready;

    always_comb begin
        enc_byte = 8'h00;
        if (protocol_reg == PROTO_THREE) begin
            case (byte_cnt_reg)
                BYTE_HEAD: enc_byte = {2'b01, nb_reg[1], nb_reg[0], cy[7:6], cx[7:6]};
                BYTE_X:    enc_byte = {2'b00, cx[5:0]};
                BYTE_Y:    enc_byte = {2'b00, cy[5:0]};
                BYTE_MID:  enc_byte = {2'b00, nb_reg[2], 5'b00000};
                default:   enc_byte = 8'h00;
            endcase
        end else begin
            case (byte_cnt_reg)
                BYTE_HEAD: enc_byte = {5'b10000, ~nb_reg[1], ~nb_reg[2], ~nb_reg[0]};
                BYTE_X:    enc_byte = cx;
                BYTE_Y:    enc_byte = cy;
                default:   enc_byte = 8'h00;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_CONTROL) begin
                        if (id_request) begin
                            state_next = ST_ID_M;
                        end
                    end else if (scan_en_reg) begin
                        if (!ring_empty) begin
                            state_next = ST_READ;
                        end else if (new_motion) begin
                            state_next = ST_ENCODE;
                        end
                    end
                end
            end
            ST_ID_M: state_next = ST_ID_3;
            ST_ID_3: state_next = ST_IDLE;
            ST_ENCODE: begin
                if (chunk_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_SEND;
            ST_SEND: begin
                if (send_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        last_btn_next = last_btn_reg;
        scan_en_next  = scan_en_reg;
        prev_dtr_next = prev_dtr_reg;
        prev_rts_next = prev_rts_reg;
        protocol_next = protocol_reg;
        byte_cnt_next = byte_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        nb_next       = nb_reg;
        mid_chg_next  = mid_chg_reg;
        ram_we        = 1'b0;
        ram_wdata     = enc_byte;
        ram_re        = 1'b0;

        if (cfg_valid) begin
            protocol_next = cfg_data[0];
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_CONTROL) begin
                        if (ctl_change) begin
                            if (in_dtr && in_rts) begin
                                scan_en_next = 1'b1;
                                if (!prev_rts_reg) begin
                                    wp_next       = '0;
                                    rp_next       = '0;
                                    last_btn_next = 3'd0;
                                end
                            end else begin
                                scan_en_next = 1'b0;
                                wp_next      = '0;
                                rp_next      = '0;
                            end
                        end
                        prev_dtr_next = in_dtr;
                        prev_rts_next = in_rts;
                    end else if (scan_en_reg && ring_empty) begin
                        last_x_next   = in_x;
                        last_y_next   = in_y;
                        last_btn_next = in_btn;
                        dx_next       = $signed({d_x[11], d_x});
                        dy_next       = (protocol_reg == PROTO_FIVE)
                                        ? -$signed({d_y[11], d_y})
                                        : $signed({d_y[11], d_y});
                        nb_next       = in_btn;
                        mid_chg_next  = btn_chg[2];
                        byte_cnt_next = BYTE_HEAD;
                    end
                end
            end
            ST_ID_M: begin
                ram_we    = 1'b1;
                ram_wdata = ID_BYTE_M;
                wp_next   = wp_inc;
            end
            ST_ID_3: begin
                ram_we    = 1'b1;
                ram_wdata = ID_BYTE_3;
                wp_next   = wp_inc;
            end
            ST_ENCODE: begin
                ram_we  = 1'b1;
                wp_next = wp_inc;
                if (last_byte) begin
                    dx_next       = rem_x;
                    dy_next       = rem_y;
                    byte_cnt_next = BYTE_HEAD;
                end else begin
                    byte_cnt_next = byte_cnt_reg + 3'd1;
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                rp_next = rp_inc;
            end
            ST_SEND: begin
                if (send_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ram_rdata;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            last_x_reg   <= 12'd0;
            last_y_reg   <= 12'd0;
            last_btn_reg <= 3'd0;
            scan_en_reg  <= 1'b0;
            prev_dtr_reg <= 1'b0;
            prev_rts_reg <= 1'b0;
            protocol_reg <= PROTO_RESET;
            byte_cnt_reg <= BYTE_HEAD;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            last_btn_reg <= last_btn_next;
            scan_en_reg  <= scan_en_next;
            prev_dtr_reg <= prev_dtr_next;
            prev_rts_reg <= prev_rts_next;
            protocol_reg <= protocol_next;
            byte_cnt_reg <= byte_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        nb_reg      <= nb_next;
        mid_chg_reg <= mid_chg_next;
    end

    smpe_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(rp_reg),
        .rdata(ram_rdata)
    );

endmodule

>>> hdl/smpe_ram.sv
// Generic simple dual-port RAM with a registered read port.
module smpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/smpe_checker.sv
// Port-level assertion checker for the serial mouse packet encoder, bound to the top level.
`include "serial_mouse_packet_encoder_top_macros.svh"

module smpe_checker import smpe_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    `SMPE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "Stalled output transfer changed")
    `SMPE_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "Output valid after reset")
    `SMPE_ASSERT(a_ctl_no_byte, aclk, aresetn, s_tvalid && s_tready && s_tuser == KIND_CONTROL |=> !$rose(m_tvalid), "Byte sent right after a control update")
    `SMPE_ASSERT(a_ready_after_send, aclk, aresetn, $rose(m_tvalid) |-> s_tready, "Input not ready after a byte was produced")
    `SMPE_ASSERT(a_busy_after_scan, aclk, aresetn, s_tready && $rose(m_tvalid) |-> $past(!s_tready), "Byte appeared without a scan in progress")

endmodule

bind serial_mouse_packet_encoder_top smpe_checker u_smpe_checker (.*);
